// ----- sv/arss_pkg.sv -----
// shared types, codes and constants of the arming / ramp safety supervisor
`timescale 1ns / 1ps

package arss_pkg;

   // result command kinds
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_DAMPING = 2'd1;
   localparam logic [1:0] KIND_RAMP    = 2'd2;
   localparam logic [1:0] KIND_POLICY  = 2'd3;

   // fault codes
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_COMMAND = 2'd1;
   localparam logic [1:0] FAULT_TILT    = 2'd2;

   // register indexes
   localparam logic [1:0] REG_STATE_TIMEOUT   = 2'd0;
   localparam logic [1:0] REG_COMMAND_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_MAX_TILT        = 2'd2;
   localparam logic [1:0] REG_RAMP_TICKS      = 2'd3;

   // register reset values
   localparam logic [15:0] RST_STATE_TIMEOUT   = 16'd150;
   localparam logic [15:0] RST_COMMAND_TIMEOUT = 16'd500;
   localparam logic [14:0] RST_MAX_TILT        = 15'd5325;
   localparam logic [15:0] RST_RAMP_TICKS      = 16'd150;

   // q1.15 one, q2.15 three, divider length
   localparam logic [15:0] Q15_ONE   = 16'd32768;
   localparam logic [16:0] Q15_THREE = 17'd98304;
   localparam int          DIV_STEPS = 15;
   localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

   typedef struct packed {
      logic               func;
      logic               enable_value;
      logic               state_present;
      logic [15:0]        state_age_ms;
      logic               command_present;
      logic [15:0]        command_age_ms;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } item_type;

   typedef struct packed {
      logic [1:0]  command_kind;
      logic [15:0] blend;
      logic        half_gain;
      logic        capture_pose;
      logic        clear_last_action;
      logic [1:0]  fault;
   } result_type;

   typedef struct packed {
      logic [15:0] state_timeout_ms;
      logic [15:0] command_timeout_ms;
      logic [14:0] max_tilt;
      logic [15:0] ramp_ticks;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic prep;
      logic div_step;
      logic square;
      logic product;
      logic finish;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic go_ramp;
      logic ramp_full;
   } status_type;

endpackage

// ----- sv/arss_datapath.sv -----
// supervisor datapath: item capture, checks, state flags, ramp divider and smoothstep
`timescale 1ns / 1ps

module arss_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  arss_pkg::cfg_type    cfg,
   input  arss_pkg::item_type   item,
   input  arss_pkg::cmd_type    cmd,
   output arss_pkg::status_type status,
   output arss_pkg::result_type result
);
   import arss_pkg::*;

   item_type    item_ff;
   result_type  res_ff, res_in;
   result_type  out_ff;
   logic        enable_req_ff, enable_req_in;
   logic        armed_ff, armed_in;
   logic        ramp_ff, ramp_in;
   logic        policy_ff, policy_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] a_ff, a_in;
   logic [15:0] rem_ff, rem_in;
   logic [30:0] sq_ff;
   logic [16:0] wt_ff;
   logic [31:0] sq_full;
   logic [47:0] prod;
   logic [16:0] rem_dbl;
   logic [15:0] abs_roll, abs_pitch;
   logic        state_stale, cmd_bad, tilt_bad;

   // freshness and tilt checks
   assign state_stale = item_ff.state_age_ms > cfg.state_timeout_ms;
   assign cmd_bad     = !item_ff.command_present ||
                        (item_ff.command_age_ms > cfg.command_timeout_ms);
   assign abs_roll    = item_ff.roll[15] ? 16'(~item_ff.roll + 16'sd1) : item_ff.roll;
   assign abs_pitch   = item_ff.pitch[15] ? 16'(~item_ff.pitch + 16'sd1) : item_ff.pitch;
   assign tilt_bad    = (abs_roll > {1'b0, cfg.max_tilt}) ||
                        (abs_pitch > {1'b0, cfg.max_tilt});

   assign status.go_ramp   = item_ff.func && item_ff.state_present && !state_stale &&
                             enable_req_ff && !cmd_bad && !tilt_bad && !policy_ff;
   assign status.ramp_full = elapsed_ff >= cfg.ramp_ticks;

   // divider step and multiplies
   assign rem_dbl = {rem_ff, 1'b0};
   assign sq_full = a_ff * a_ff;
   assign prod    = sq_ff * wt_ff;

   // state flags and working result
   always_comb begin
      enable_req_in = enable_req_ff;
      armed_in      = armed_ff;
      ramp_in       = ramp_ff;
      policy_in     = policy_ff;
      elapsed_in    = elapsed_ff;
      res_in        = res_ff;
      a_in          = a_ff;
      rem_in        = rem_ff;
      if (cmd.eval) begin
         res_in = '0;
         priority if (!item_ff.func) begin
            enable_req_in = item_ff.enable_value;
            if (!item_ff.enable_value) begin
               ramp_in   = 1'b0;
               policy_in = 1'b0;
            end
         end else if (!item_ff.state_present) begin
            res_in.command_kind = KIND_NONE;
         end else if (state_stale || !enable_req_ff) begin
            res_in.command_kind = armed_ff ? KIND_DAMPING : KIND_NONE;
         end else if (cmd_bad) begin
            enable_req_in       = 1'b0;
            ramp_in             = 1'b0;
            policy_in           = 1'b0;
            res_in.command_kind = KIND_DAMPING;
            res_in.fault        = FAULT_COMMAND;
         end else if (tilt_bad) begin
            enable_req_in       = 1'b0;
            ramp_in             = 1'b0;
            policy_in           = 1'b0;
            res_in.command_kind = KIND_DAMPING;
            res_in.fault        = FAULT_TILT;
         end else if (!policy_ff) begin
            // ramp tick, arming first if not yet running
            if (!ramp_ff) begin
               ramp_in             = 1'b1;
               armed_in            = 1'b1;
               elapsed_in          = '0;
               res_in.capture_pose = 1'b1;
            end
         end else begin
            res_in.command_kind = KIND_POLICY;
         end
      end
      if (cmd.prep) begin
         a_in   = status.ramp_full ? Q15_ONE : '0;
         rem_in = elapsed_ff;
      end
      if (cmd.div_step) begin
         if (rem_dbl >= {1'b0, cfg.ramp_ticks}) begin
            rem_in = 16'(rem_dbl - {1'b0, cfg.ramp_ticks});
            a_in   = {a_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_dbl[15:0];
            a_in   = {a_ff[14:0], 1'b0};
         end
      end
      if (cmd.product) begin
         res_in.blend = prod[45:30];
      end
      if (cmd.finish) begin
         res_in.command_kind = KIND_RAMP;
         res_in.half_gain    = 1'b1;
         if (elapsed_ff != 16'hFFFF) begin
            elapsed_in = elapsed_ff + 16'd1;
         end
         if (a_ff[15]) begin
            ramp_in                  = 1'b0;
            policy_in                = 1'b1;
            res_in.clear_last_action = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_req_ff <= 1'b0;
         armed_ff      <= 1'b0;
         ramp_ff       <= 1'b0;
         policy_ff     <= 1'b0;
         elapsed_ff    <= '0;
      end else begin
         enable_req_ff <= enable_req_in;
         armed_ff      <= armed_in;
         ramp_ff       <= ramp_in;
         policy_ff     <= policy_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= item;
      end
      res_ff <= res_in;
      a_ff   <= a_in;
      rem_ff <= rem_in;
      if (cmd.square) begin
         sq_ff <= sq_full[30:0];
         wt_ff <= 17'(Q15_THREE - {a_ff, 1'b0});
      end
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   assign result = out_ff;

   // ramp and policy never run together
   assert property (@(posedge clock) disable iff (reset) !(ramp_ff && policy_ff))
      else $error("ramp and policy both running");

   // a finished ramp hands over to the policy
   assert property (@(posedge clock) disable iff (reset)
                    cmd.finish && a_ff[15] |=> policy_ff && !ramp_ff)
      else $error("ramp end did not start policy");

endmodule

// ----- sv/arss_ctrl.sv -----
// supervisor controller: sequences evaluation, divider, multiplies and result handoff
`timescale 1ns / 1ps

module arss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  arss_pkg::status_type status,
   output arss_pkg::cmd_type    cmd
);
   import arss_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_EVAL = 8'b00000010,
      ST_PREP = 8'b00000100,
      ST_DIV  = 8'b00001000,
      ST_SQ   = 8'b00010000,
      ST_PROD = 8'b00100000,
      ST_FIN  = 8'b01000000,
      ST_HOLD = 8'b10000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.go_ramp ? ST_PREP : ST_HOLD;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = status.ramp_full ? ST_SQ : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.product = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid flag
   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
                    valid_ff && !rsp_tready |-> !cmd.load_out)
      else $error("result overwritten before transfer");

   // an input transfer always starts evaluation
   assert property (@(posedge clock) disable iff (reset)
                    req_tvalid && req_tready |=> state_ff == ST_EVAL)
      else $error("accepted item not evaluated");

   // the divider runs exactly its step count
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == ST_DIV && cnt_ff == DIV_LAST |=> state_ff == ST_SQ)
      else $error("divider step count wrong");

endmodule

// ----- sv/arming_ramp_safety_supervisor_top.sv -----
// top level of the arming / ramp safety supervisor: stream ports, register file, core
`timescale 1ns / 1ps

// Safety supervisor for a legged joint controller. Each input transfer is an enable
// message or a control tick (tuser selects); each gives exactly one result transfer.
// An enable message or a tick that does not run the pose ramp passes through evaluation
// and the result hold before the next item is taken; a ramp tick also runs the
// 15-step restoring divider that forms elapsed/ramp_ticks in Q1.15, followed by two
// registered multiplies for the smoothstep weight (the divider is skipped when the ramp
// is already at its end). A finished result waits in an output register while the next
// item is taken. Registers (APB, byte address 4*i): 0 state_timeout_ms, 1 command_timeout_ms,
// 2 max_tilt, 3 ramp_ticks; write them only while the block is idle.
module arming_ramp_safety_supervisor_top (
   input  logic        clock,
   input  logic        reset,
   // tdata: enable_value, state_present, state_age_ms[16], command_present,
   //        command_age_ms[16], roll[16], pitch[16], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // tuser: func
   input  logic        req_tuser,
   // tdata: blend[16], half_gain, capture_pose, clear_last_action, fault[2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // tuser: command_kind[2]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import arss_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   result_type result;
   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_STATE_TIMEOUT:   cfg_in.state_timeout_ms   = csr_pwdata[15:0];
            REG_COMMAND_TIMEOUT: cfg_in.command_timeout_ms = csr_pwdata[15:0];
            REG_MAX_TILT:        cfg_in.max_tilt           = csr_pwdata[14:0];
            REG_RAMP_TICKS:      cfg_in.ramp_ticks         = csr_pwdata[15:0];
            default:             cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.state_timeout_ms   <= RST_STATE_TIMEOUT;
         cfg_ff.command_timeout_ms <= RST_COMMAND_TIMEOUT;
         cfg_ff.max_tilt           <= RST_MAX_TILT;
         cfg_ff.ramp_ticks         <= RST_RAMP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_STATE_TIMEOUT:   csr_prdata = {16'd0, cfg_ff.state_timeout_ms};
         REG_COMMAND_TIMEOUT: csr_prdata = {16'd0, cfg_ff.command_timeout_ms};
         REG_MAX_TILT:        csr_prdata = {17'd0, cfg_ff.max_tilt};
         REG_RAMP_TICKS:      csr_prdata = {16'd0, cfg_ff.ramp_ticks};
         default:             csr_prdata = '0;
      endcase
   end

   // unpack input transfer
   assign item.func            = req_tuser;
   assign item.enable_value    = req_tdata[0];
   assign item.state_present   = req_tdata[1];
   assign item.state_age_ms    = req_tdata[17:2];
   assign item.command_present = req_tdata[18];
   assign item.command_age_ms  = req_tdata[34:19];
   assign item.roll            = req_tdata[50:35];
   assign item.pitch           = req_tdata[66:51];

   // pack result transfer
   assign rsp_tuser = result.command_kind;
   assign rsp_tdata = {3'd0, result.fault, result.clear_last_action, result.capture_pose,
                       result.half_gain, result.blend};

   arss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   arss_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .item   (item),
      .cmd    (cmd),
      .status (status),
      .result (result)
   );

endmodule

// ----- bench/arming_ramp_safety_supervisor_top_test.sv -----
// self-checking testbench for the arming / ramp safety supervisor top level
`timescale 1ns / 1ps

module arming_ramp_safety_supervisor_top_test;
   import arss_pkg::*;

   // predicts the command for each accepted message and checks results in order
   class command_scoreboard;
      cfg_type     limits;
      logic        enable_req;
      logic        armed;
      logic        ramp_on;
      logic        policy_on;
      logic [15:0] ramp_count;
      result_type  due_commands[$];
      int          mismatches;

      function new();
         limits.state_timeout_ms   = RST_STATE_TIMEOUT;
         limits.command_timeout_ms = RST_COMMAND_TIMEOUT;
         limits.max_tilt           = RST_MAX_TILT;
         limits.ramp_ticks         = RST_RAMP_TICKS;
         enable_req = 1'b0;
         armed      = 1'b0;
         ramp_on    = 1'b0;
         policy_on  = 1'b0;
         ramp_count = '0;
         mismatches = 0;
      endfunction

      function void set_limit(logic [1:0] index, logic [15:0] value);
         case (index)
            REG_STATE_TIMEOUT:   limits.state_timeout_ms   = value;
            REG_COMMAND_TIMEOUT: limits.command_timeout_ms = value;
            REG_MAX_TILT:        limits.max_tilt           = value[14:0];
            default:             limits.ramp_ticks         = value;
         endcase
      endfunction

      // fail-safe drops the enable, the ramp and the policy
      function void drop_to_safe();
         enable_req = 1'b0;
         ramp_on    = 1'b0;
         policy_on  = 1'b0;
      endfunction

      function void predict_command(item_type m);
         result_type        want;
         int                roll_mag;
         int                pitch_mag;
         longint unsigned   frac;
         longint unsigned   span;
         longint unsigned   count;
         want      = '0;
         roll_mag  = m.roll;
         pitch_mag = m.pitch;
         if (roll_mag < 0) roll_mag = -roll_mag;
         if (pitch_mag < 0) pitch_mag = -pitch_mag;
         if (!m.func) begin
            // enable message
            enable_req = m.enable_value;
            if (!enable_req) begin
               ramp_on   = 1'b0;
               policy_on = 1'b0;
            end
         end else if (m.state_present) begin
            if (m.state_age_ms > limits.state_timeout_ms || !enable_req) begin
               want.command_kind = armed ? KIND_DAMPING : KIND_NONE;
            end else if (!m.command_present ||
                         m.command_age_ms > limits.command_timeout_ms) begin
               drop_to_safe();
               want.command_kind = KIND_DAMPING;
               want.fault        = FAULT_COMMAND;
            end else if (roll_mag > int'(limits.max_tilt) ||
                         pitch_mag > int'(limits.max_tilt)) begin
               drop_to_safe();
               want.command_kind = KIND_DAMPING;
               want.fault        = FAULT_TILT;
            end else begin
               // arm the pose ramp from rest
               if (!policy_on && !ramp_on) begin
                  ramp_on           = 1'b1;
                  armed             = 1'b1;
                  ramp_count        = '0;
                  want.capture_pose = 1'b1;
               end
               if (ramp_on) begin
                  span  = limits.ramp_ticks;
                  count = ramp_count;
                  if (count >= span) frac = Q15_ONE;
                  else frac = (count * Q15_ONE) / span;
                  want.command_kind = KIND_RAMP;
                  want.half_gain    = 1'b1;
                  want.blend = 16'((frac * frac * (longint'(Q15_THREE) - 2 * frac)) >> 30);
                  if (ramp_count != 16'hFFFF) ramp_count = ramp_count + 16'd1;
                  // ramp end hands over to the policy
                  if (frac >= Q15_ONE) begin
                     ramp_on                = 1'b0;
                     policy_on              = 1'b1;
                     want.clear_last_action = 1'b1;
                  end
               end else begin
                  want.command_kind = KIND_POLICY;
               end
            end
         end
         due_commands.insert(due_commands.size(), want);
      endfunction

      function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v,
                     got_v);
            mismatches++;
         end
      endfunction

      function void check_command(result_type got);
         result_type want;
         if (due_commands.size() == 0) begin
            $display("%0t: result with nothing due, expected none, actual kind %0d blend %0d",
                     $time, got.command_kind, got.blend);
            mismatches++;
            return;
         end
         want = due_commands.pop_front();
         compare_field("command_kind", 16'(want.command_kind), 16'(got.command_kind));
         compare_field("blend", want.blend, got.blend);
         compare_field("half_gain", 16'(want.half_gain), 16'(got.half_gain));
         compare_field("capture_pose", 16'(want.capture_pose), 16'(got.capture_pose));
         compare_field("clear_last_action", 16'(want.clear_last_action),
                       16'(got.clear_last_action));
         compare_field("fault", 16'(want.fault), 16'(got.fault));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   command_scoreboard board = new();
   int                calm_left = 0;

   arming_ramp_safety_supervisor_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // sender gap: mostly none or short, a few long, with calm stretches
   function automatic int idle_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [15:0] pick_age(int lim);
      case ($urandom_range(0, 3))
         0:       return 16'd0;
         1:       return 16'(lim);
         default: return 16'($urandom_range(0, lim));
      endcase
   endfunction

   // angle within the tilt limit, either sign
   function automatic logic [15:0] pick_angle(int lim);
      int mag;
      case ($urandom_range(0, 3))
         0:       mag = 0;
         1:       mag = lim;
         default: mag = $urandom_range(0, lim);
      endcase
      return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
   endfunction

   // angle just or well past the tilt limit
   function automatic logic [15:0] over_angle(int lim);
      int mag;
      mag = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 32768);
      return (mag == 32768 || $urandom_range(0, 1)) ? 16'(-mag) : 16'(mag);
   endfunction

   function automatic item_type enable_msg(logic value);
      item_type    m;
      logic [95:0] raw;
      raw            = {$urandom, $urandom, $urandom};
      m              = raw[67:0];
      m.func         = 1'b0;
      m.enable_value = value;
      return m;
   endfunction

   function automatic item_type tick_msg(logic sp, logic [15:0] sage, logic cp,
                                         logic [15:0] cage, logic [15:0] roll,
                                         logic [15:0] pitch);
      item_type m;
      m.func            = 1'b1;
      m.enable_value    = 1'($urandom);
      m.state_present   = sp;
      m.state_age_ms    = sage;
      m.command_present = cp;
      m.command_age_ms  = cage;
      m.roll            = roll;
      m.pitch           = pitch;
      return m;
   endfunction

   // mostly well-formed ticks, some enable messages; noise and broken ticks at the given rate
   function automatic item_type random_message(int disturb_pct);
      item_type    m;
      logic [95:0] raw;
      int          pick;
      int          st;
      int          ct;
      int          tilt;
      raw  = {$urandom, $urandom, $urandom};
      m    = raw[67:0];
      st   = board.limits.state_timeout_ms;
      ct   = board.limits.command_timeout_ms;
      tilt = board.limits.max_tilt;
      pick = $urandom_range(0, 99);
      if (pick < disturb_pct) return m;
      if (pick < disturb_pct + 10)
         return enable_msg($urandom_range(0, 99) >= 3 * disturb_pct);
      m = tick_msg(1'b1, pick_age(st), 1'b1, pick_age(ct), pick_angle(tilt),
                   pick_angle(tilt));
      if ($urandom_range(0, 99) < disturb_pct) begin
         case ($urandom_range(0, 4))
            0: m.state_present = 1'b0;
            1: begin
               if (st < 65535) m.state_age_ms = 16'($urandom_range(st + 1, 65535));
               else m.state_present = 1'b0;
            end
            2: m.command_present = 1'b0;
            3: begin
               if (ct < 65535) m.command_age_ms = 16'($urandom_range(ct + 1, 65535));
               else m.command_present = 1'b0;
            end
            default: begin
               if ($urandom_range(0, 1)) m.roll = over_angle(tilt);
               else m.pitch = over_angle(tilt);
            end
         endcase
      end
      return m;
   endfunction

   // one input transfer, preceded by a random gap
   task automatic send_message(input item_type m);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m.func;
      req_tdata  <= {5'b0, m.pitch, m.roll, m.command_age_ms, m.command_present,
                     m.state_age_ms, m.state_present, m.enable_value};
      do @(posedge clock); while (!req_tready);
      board.predict_command(m);
   endtask

   task automatic wait_drained();
      while (board.due_commands.size() != 0) @(posedge clock);
   endtask

   // back-to-back register writes, psel held between them
   task automatic apply_limits(input logic [15:0] st, input logic [15:0] ct,
                               input logic [15:0] tilt, input logic [15:0] ramp);
      logic [15:0] value [4];
      value[REG_STATE_TIMEOUT]   = st;
      value[REG_COMMAND_TIMEOUT] = ct;
      value[REG_MAX_TILT]        = tilt;
      value[REG_RAMP_TICKS]      = ramp;
      for (int i = 0; i < 4; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {2'(i), 2'b00};
         csr_pwdata  <= 32'(value[i]);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         board.set_limit(2'(i), value[i]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_phase(input int st, input int ct, input int tilt, input int ramp,
                            input int count, input int disturb_pct);
      req_tvalid <= 1'b0;
      wait_drained();
      apply_limits(16'(st), 16'(ct), 16'(tilt), 16'(ramp));
      repeat (count) send_message(random_message(disturb_pct));
   endtask

   // result side: stretches of ready, short and long stalls
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 40)) @(posedge clock);
            end
            9: begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 60)) @(posedge clock);
            end
            default: begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
         endcase
      end
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_command({rsp_tuser, rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[17],
                              rsp_tdata[18], rsp_tdata[20:19]});
   end

   // stimulus
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with reset limits
      send_message(tick_msg(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 16'h7FFF, 16'h8000));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_message(enable_msg(1'b0));
      send_message(enable_msg(1'b1));
      send_message(tick_msg(1'b1, 16'd151, 1'b1, 16'd0, 16'd0, 16'd0));
      send_message(tick_msg(1'b1, 16'd150, 1'b0, 16'd0, 16'd0, 16'd0));
      send_message(enable_msg(1'b1));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd501, 16'd0, 16'd0));
      send_message(enable_msg(1'b1));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, 16'd5326, 16'd0));
      send_message(enable_msg(1'b1));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, 16'd0, 16'h8000));
      send_message(enable_msg(1'b1));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, 16'h7FFF, 16'd0));
      send_message(enable_msg(1'b1));
      // limits exactly met: arms the ramp
      send_message(tick_msg(1'b1, 16'd150, 1'b1, 16'd500, 16'd5325, -16'sd5325));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, -16'sd5325, 16'd5325));
      // stale state once armed gives damping
      send_message(tick_msg(1'b1, 16'hFFFF, 1'b1, 16'd0, 16'd0, 16'd0));
      send_message(tick_msg(1'b0, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_message(enable_msg(1'b0));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_message(enable_msg(1'b1));
      send_message(tick_msg(1'b1, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0));

      // random phases over several limit settings
      run_phase(150, 500, 5325, 150, 300, 0);
      run_phase(65535, 65535, 32767, 1, 300, 10);
      run_phase(0, 0, 0, 0, 250, 10);
      run_phase(40, 100, 8192, 5, 300, 12);
      run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 32767), $urandom_range(1, 12), 300, 15);
      run_phase(1, 1, 1, 65535, 200, 5);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      if (board.mismatches == 0 && board.due_commands.size() == 0)
         $display("arming_ramp_safety_supervisor_top test passed");
      else
         $display("arming_ramp_safety_supervisor_top test failed");
      $finish;
   end

   // run time limit
   initial begin
      #20_000_000;
      $display("arming_ramp_safety_supervisor_top test failed");
      $finish;
   end

endmodule
